// File: hdl/dbm_pkg.sv
// Shared types, widths and segment constants of the dB meter scale mapper.
package dbm_pkg;

    localparam int DB_W   = 17;           // level fields, 1/256 dB, signed
    localparam int POS_W  = 17;           // position fields, Q16
    localparam int SEG_N  = 5;            // linear segments of the scale
    localparam int F_W    = 21;           // width of 6*level compares
    localparam int A_W    = 18;           // first multiplier operand
    localparam int B_W    = 17;           // second multiplier operand
    localparam int P_W    = A_W + B_W;    // full product
    localparam int N_W    = 33;           // dividend
    localparam int DEN_W  = 18;           // divisor
    localparam int Q_W    = 17;           // quotient bits, one per divider stage
    localparam int REM_W  = DEN_W + Q_W;  // compare width in the divider

    localparam logic [POS_W-1:0] FULL_SCALE = 17'd65536;
    localparam logic signed [DB_W-1:0] RANGE_RST = -17'sd15360;
    localparam logic signed [DB_W-1:0] RANGE_MAX = -17'sd256;

    typedef enum logic {
        CMD_DB2POS = 1'b0,
        CMD_POS2DB = 1'b1
    } t_cmd;

    // Segment k runs from position MARK_LO[k] + SPAN[k] down to MARK_LO[k], and in
    // dB from range*(KR[k]-KD[k])/6 down to range*KR[k]/6.
    localparam logic [POS_W-1:0] MARK_LO [SEG_N] = '{
        17'd32768, 17'd19661, 17'd9830, 17'd4915, 17'd0};
    localparam logic [POS_W-1:0] SPAN [SEG_N] = '{
        17'd32768, 17'd13107, 17'd9831, 17'd4915, 17'd4915};
    localparam logic [2:0] KR [SEG_N] = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
    localparam logic [1:0] KD [SEG_N] = '{2'd2, 2'd1, 2'd1, 2'd1, 2'd1};
    // KR[k] * SPAN[k] and 6 * SPAN[k].
    localparam logic [DEN_W-1:0] KSPAN [SEG_N] = '{
        18'd65536, 18'd39321, 18'd39324, 18'd24575, 18'd29490};
    localparam logic [DEN_W-1:0] SPAN6 [SEG_N] = '{
        18'd196608, 18'd78642, 18'd58986, 18'd29490, 18'd29490};

    typedef struct packed {
        logic [A_W-1:0]   a;
        logic [B_W-1:0]   b;
        logic [DEN_W-1:0] c;
        logic [DEN_W-1:0] den;
        logic [POS_W-1:0] base;
        t_cmd             cmd;
    } t_mac_req;

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [DEN_W-1:0] den;
        logic [POS_W-1:0] base;
        t_cmd             cmd;
    } t_div_req;

    typedef struct packed {
        logic [N_W-1:0]   rem;
        logic [Q_W-1:0]   quo;
        logic [DEN_W-1:0] den;
        logic [POS_W-1:0] base;
        t_cmd             cmd;
    } t_div_st;

endpackage

// File: hdl/dbm_ifs.sv
// Request and response stream interfaces of the dB meter scale mapper.
interface dbm_in_if;
    logic                               valid;
    logic                               ready;
    dbm_pkg::t_cmd                      cmd;
    logic signed [dbm_pkg::DB_W-1:0]    db_in;
    logic        [dbm_pkg::POS_W-1:0]   position_in;

    modport source (output valid, cmd, db_in, position_in, input ready);
    modport sink   (input valid, cmd, db_in, position_in, output ready);
endinterface

interface dbm_out_if;
    logic                               valid;
    logic                               ready;
    logic        [dbm_pkg::POS_W-1:0]   position_out;
    logic signed [dbm_pkg::DB_W-1:0]    db_out;

    modport source (output valid, position_out, db_out, input ready);
    modport sink   (input valid, position_out, db_out, output ready);
endinterface

// File: hdl/db_meter_scale_mapper.sv
// Top level of the piecewise linear dB meter scale mapper.
//
//  Port          Dir   Handshake      Carries
//  i_req         in    valid/ready    cmd, db_in, position_in
//  o_rsp         out   valid/ready    position_out, db_out
//  i_cfg_we      in    write enable   i_cfg_wdata -> db_range
//
// One request enters per cycle while the pipeline is not stalled; its result passes
// through the segment select and multiply-add registers, the divider stages (one
// quotient bit per stage) and one output register. Reset is synchronous and active
// low; it clears all valid bits and sets db_range to -60 dB. A stalled output holds
// each stage that is full, while empty stages in front still take requests.
module db_meter_scale_mapper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dbm_pkg::DB_W-1:0]        i_cfg_wdata,
    dbm_in_if.sink                          i_req,
    dbm_out_if.source                       o_rsp
);

    logic signed [dbm_pkg::DB_W-1:0]    r_range;
    logic signed [dbm_pkg::DB_W-1:0]    n_range;

    logic                               w_seg_vld;
    logic                               w_seg_rdy;
    dbm_pkg::t_mac_req                  w_seg_data;
    logic                               w_mac_vld;
    logic                               w_mac_rdy;
    dbm_pkg::t_div_req                  w_mac_data;
    logic                               w_div_vld;
    logic                               w_div_rdy;
    dbm_pkg::t_div_st                   w_div_data;

    logic                               r_out_vld;
    logic        [dbm_pkg::POS_W-1:0]   r_pos;
    logic        [dbm_pkg::POS_W-1:0]   n_pos;
    logic signed [dbm_pkg::DB_W-1:0]    r_db;
    logic signed [dbm_pkg::DB_W-1:0]    n_db;

    // The register keeps the effective range: anything above -1 dB reads as -1 dB.
    always_comb begin
        n_range = $signed(i_cfg_wdata);
        if ($signed(i_cfg_wdata) > dbm_pkg::RANGE_MAX) begin
            n_range = dbm_pkg::RANGE_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= dbm_pkg::RANGE_RST;
        end else if (i_cfg_we) begin
            r_range <= n_range;
        end
    end

    dbm_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_range (r_range),
        .o_valid (w_seg_vld),
        .i_ready (w_seg_rdy),
        .o_data  (w_seg_data)
    );

    dbm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_seg_vld),
        .o_ready (w_seg_rdy),
        .i_data  (w_seg_data),
        .o_valid (w_mac_vld),
        .i_ready (w_mac_rdy),
        .o_data  (w_mac_data)
    );

    dbm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mac_vld),
        .o_ready (w_mac_rdy),
        .i_data  (w_mac_data),
        .o_valid (w_div_vld),
        .i_ready (w_div_rdy),
        .o_data  (w_div_data)
    );

    assign w_div_rdy = !r_out_vld || o_rsp.ready;

    always_comb begin
        n_pos = '0;
        n_db  = '0;
        if (w_div_data.cmd == dbm_pkg::CMD_DB2POS) begin
            n_pos = w_div_data.base + w_div_data.quo;
        end else begin
            n_db = $signed(w_div_data.base - w_div_data.quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_div_rdy) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_rdy) begin
            r_pos <= n_pos;
            r_db  <= n_db;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.position_out = r_pos;
    assign o_rsp.db_out       = r_db;

    a_range_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_range <= dbm_pkg::RANGE_MAX)
        else $error("effective range is not below -1 dB");

    a_pos_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.position_out <= dbm_pkg::FULL_SCALE)
        else $error("position beyond full scale");

    a_db_not_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.db_out <= 17'sd0)
                        && (o_rsp.db_out >= r_range || o_rsp.db_out == 17'sd0))
        else $error("level outside the configured scale");

endmodule

// File: hdl/dbm_seg.sv
// Segment select stage: finds the scale segment and sets up the multiply and divide.
module dbm_seg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dbm_in_if.sink                              i_req,
    input  logic signed [dbm_pkg::DB_W-1:0]     i_range,
    output logic                                o_valid,
    input  logic                                i_ready,
    output dbm_pkg::t_mac_req                   o_data
);

    logic                               r_vld;
    dbm_pkg::t_mac_req                  r_data;
    dbm_pkg::t_mac_req                  n_data;
    logic                               w_load;
    logic        [dbm_pkg::DB_W-1:0]    w_mag;
    logic signed [dbm_pkg::F_W-1:0]     w_r_ext;
    logic signed [dbm_pkg::F_W-1:0]     w_d6;
    logic signed [dbm_pkg::F_W-1:0]     w_rk [dbm_pkg::SEG_N];

    assign w_load      = !r_vld || i_ready;
    assign i_req.ready = w_load;
    assign o_valid     = r_vld;
    assign o_data      = r_data;

    always_comb begin
        w_mag   = dbm_pkg::DB_W'(~i_range + 17'd1);
        w_r_ext = dbm_pkg::F_W'(i_range);
        w_d6    = dbm_pkg::F_W'(i_req.db_in) * dbm_pkg::F_W'(6);
        for (int k = 0; k < dbm_pkg::SEG_N; k++) begin
            w_rk[k] = w_r_ext * dbm_pkg::F_W'(dbm_pkg::KR[k]);
        end

        // An empty multiply with divisor one makes the quotient zero.
        n_data.a    = '0;
        n_data.b    = '0;
        n_data.c    = '0;
        n_data.den  = dbm_pkg::DEN_W'(1);
        n_data.base = '0;
        n_data.cmd  = i_req.cmd;

        if (i_req.cmd == dbm_pkg::CMD_DB2POS) begin
            if (i_req.db_in > 17'sd0) begin
                n_data.base = dbm_pkg::FULL_SCALE;
            end else begin
                // Descending order leaves the topmost matching segment.
                for (int k = dbm_pkg::SEG_N - 1; k >= 0; k--) begin
                    if (w_d6 > w_rk[k]) begin
                        n_data.a    = dbm_pkg::A_W'(w_d6 - w_rk[k]);
                        n_data.b    = dbm_pkg::B_W'(dbm_pkg::SPAN[k]);
                        n_data.den  = dbm_pkg::DEN_W'(dbm_pkg::DEN_W'(w_mag)
                                      * dbm_pkg::DEN_W'(dbm_pkg::KD[k]));
                        n_data.base = dbm_pkg::MARK_LO[k];
                    end
                end
            end
        end else begin
            if (i_req.position_in < dbm_pkg::FULL_SCALE) begin
                n_data.base = dbm_pkg::POS_W'(i_range);
                for (int k = dbm_pkg::SEG_N - 1; k >= 0; k--) begin
                    if (i_req.position_in > dbm_pkg::MARK_LO[k]) begin
                        // The level is -ceil(|range| * y / (6 * span)).
                        n_data.a    = dbm_pkg::A_W'(w_mag);
                        n_data.b    = dbm_pkg::B_W'(dbm_pkg::KSPAN[k]
                                      - dbm_pkg::DEN_W'(dbm_pkg::DEN_W'(
                                        i_req.position_in - dbm_pkg::MARK_LO[k])
                                        * dbm_pkg::DEN_W'(dbm_pkg::KD[k])));
                        n_data.den  = dbm_pkg::SPAN6[k];
                        n_data.c    = dbm_pkg::SPAN6[k] - dbm_pkg::DEN_W'(1);
                        n_data.base = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

endmodule

// File: hdl/dbm_mac.sv
// Multiply-add stage that forms the dividend.
module dbm_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dbm_pkg::t_mac_req   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output dbm_pkg::t_div_req   o_data
);

    logic                       r_vld;
    dbm_pkg::t_div_req          r_data;
    dbm_pkg::t_div_req          n_data;
    logic                       w_load;
    logic [dbm_pkg::P_W-1:0]    w_prod;

    assign w_load  = !r_vld || i_ready;
    assign o_ready = w_load;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_comb begin
        w_prod      = dbm_pkg::P_W'(i_data.a) * dbm_pkg::P_W'(i_data.b);
        n_data.n    = dbm_pkg::N_W'(w_prod + dbm_pkg::P_W'(i_data.c));
        n_data.den  = i_data.den;
        n_data.base = i_data.base;
        n_data.cmd  = i_data.cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

endmodule

// File: hdl/dbm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module dbm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dbm_pkg::t_div_req   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output dbm_pkg::t_div_st    o_data
);

    localparam int LAST = dbm_pkg::Q_W - 1;

    logic [dbm_pkg::Q_W-1:0]    r_vld;
    dbm_pkg::t_div_st           r_st [dbm_pkg::Q_W];
    logic [dbm_pkg::Q_W:0]      w_rdy;
    logic [dbm_pkg::Q_W-1:0]    w_src_vld;
    dbm_pkg::t_div_st           w_src [dbm_pkg::Q_W];

    always_comb begin
        w_rdy[dbm_pkg::Q_W] = i_ready;
        for (int k = dbm_pkg::Q_W - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_src_vld[0]  = i_valid;
        w_src[0].rem  = i_data.n;
        w_src[0].quo  = '0;
        w_src[0].den  = i_data.den;
        w_src[0].base = i_data.base;
        w_src[0].cmd  = i_data.cmd;
        for (int k = 1; k < dbm_pkg::Q_W; k++) begin
            w_src_vld[k] = r_vld[k-1];
            w_src[k]     = r_st[k-1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[LAST];
    assign o_data  = r_st[LAST];

    for (genvar k = 0; k < dbm_pkg::Q_W; k++) begin : g_stage
        logic [dbm_pkg::REM_W-1:0]  w_sh;
        logic [dbm_pkg::REM_W:0]    w_diff;
        dbm_pkg::t_div_st           n_st;

        // Stage k tries the divisor shifted to quotient bit LAST - k.
        always_comb begin
            n_st   = w_src[k];
            w_sh   = dbm_pkg::REM_W'(w_src[k].den) << (LAST - k);
            w_diff = {1'b0, dbm_pkg::REM_W'(w_src[k].rem)} - {1'b0, w_sh};
            if (!w_diff[dbm_pkg::REM_W]) begin
                n_st.rem          = w_diff[dbm_pkg::N_W-1:0];
                n_st.quo[LAST - k] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= w_src_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_st[k] <= n_st;
            end
        end
    end

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] |-> (dbm_pkg::DEN_W'(r_st[LAST].rem) < r_st[LAST].den)
                        && (r_st[LAST].rem < dbm_pkg::N_W'(r_st[LAST].den)))
        else $error("divider remainder not below divisor");

    a_fwd_quo_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && r_st[LAST].cmd == dbm_pkg::CMD_DB2POS)
        |-> r_st[LAST].quo <= dbm_pkg::SPAN[0])
        else $error("position step exceeds widest segment");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !w_rdy[1]) |=> r_vld[0] && $stable(r_st[0]))
        else $error("first divider stage lost a stalled request");

endmodule
